/* rtl/scalar_kalman_filter_top_assert.svh */
// assertion macros for the scalar kalman filter
`ifndef SCALAR_KALMAN_FILTER_TOP_ASSERT_SVH
`define SCALAR_KALMAN_FILTER_TOP_ASSERT_SVH

// generic clocked check with a reset that disables it
`define SKF_ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check on the block's own clock and reset
`define SKF_ASSERT(label, prop, msg) \
   `SKF_ASSERT_CLK(label, clock, reset, prop, msg)

`endif

/* rtl/skf_pkg.sv */
// shared constants and types of the scalar kalman filter
package skf_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int FRAC_BITS  = 16;
   localparam int GAIN_W     = FRAC_BITS + 1;
   localparam int MAG_W      = DATA_WIDTH + 1;
   localparam int PROD_W     = MAG_W + GAIN_W;
   localparam int CNT_W      = $clog2(FRAC_BITS);
   localparam int IDX_W      = 2;

   localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << FRAC_BITS;

   localparam logic [DATA_WIDTH-1:0] RST_Q = DATA_WIDTH'(7);
   localparam logic [DATA_WIDTH-1:0] RST_R = DATA_WIDTH'(13107200);
   localparam logic [DATA_WIDTH-1:0] RST_X = DATA_WIDTH'(2621440);
   localparam logic [DATA_WIDTH-1:0] RST_P = DATA_WIDTH'(65536000);

   typedef enum logic [IDX_W-1:0] {
      REG_PROCESS_NOISE      = 2'd0,
      REG_MEASUREMENT_NOISE  = 2'd1,
      REG_INITIAL_ESTIMATE   = 2'd2,
      REG_INITIAL_COVARIANCE = 2'd3
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PRED,
      ST_DEN,
      ST_DIV,
      ST_MULX,
      ST_MULP,
      ST_DONE
   } state_type;

endpackage

/* rtl/scalar_kalman_filter_top.sv */
// scalar kalman filter top level: one request beat in, one result beat out per update
// an update runs through prediction, denominator, 16 gain-division steps, two multiplies on one
//   shared multiplier and write-back; the division steps are skipped when r is zero
// a new beat is taken only once the previous update is finished; the gain divider works one bit
//   per cycle, and a finished result waits while the previous result beat is stalled
// reset: synchronous, restores registers to defaults and estimate/covariance to initial values
`include "scalar_kalman_filter_top_assert.svh"

module scalar_kalman_filter_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [skf_pkg::DATA_WIDTH-1:0] req_measurement,
   input  logic                               req_restart,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [skf_pkg::DATA_WIDTH-1:0] rsp_estimate,
   output logic        [skf_pkg::DATA_WIDTH-1:0] rsp_covariance,
   output logic        [skf_pkg::GAIN_W-1:0]     rsp_gain,
   input  logic                               csr_write,
   input  logic        [skf_pkg::IDX_W-1:0]      csr_index,
   input  logic        [skf_pkg::DATA_WIDTH-1:0] csr_wdata
);

   localparam int DW = skf_pkg::DATA_WIDTH;
   localparam int FB = skf_pkg::FRAC_BITS;
   localparam int GW = skf_pkg::GAIN_W;
   localparam int MW = skf_pkg::MAG_W;
   localparam int PW = skf_pkg::PROD_W;
   localparam int CW = skf_pkg::CNT_W;

   skf_pkg::state_type state_ff, state_in;

   logic [DW-1:0] q_ff, q_in;
   logic [DW-1:0] r_ff, r_in;
   logic [DW-1:0] x0_ff, x0_in;
   logic [DW-1:0] p0_ff, p0_in;
   logic [DW-1:0] x_ff, x_in;
   logic [DW-1:0] p_ff, p_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic [DW-1:0] z_ff, z_in;
   logic [DW-1:0] p1_ff, p1_in;
   logic [MW-1:0] mag_ff, mag_in;
   logic          neg_ff, neg_in;
   logic [MW-1:0] den_ff, den_in;
   logic [MW-1:0] rem_ff, rem_in;
   logic [GW-1:0] k_ff, k_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [PW-1:0] prod_ff, prod_in;
   logic [DW-1:0] est_out_ff, est_out_in;
   logic [DW-1:0] cov_out_ff, cov_out_in;
   logic [GW-1:0] gain_out_ff, gain_out_in;

   logic          req_fire;
   logic [MW-1:0] p_sum;
   logic [MW-1:0] diff;
   logic [MW:0]   rem_sh;
   logic [MW:0]   rem_sub;
   logic [MW-1:0] mul_a;
   logic [GW-1:0] mul_b;
   logic [MW-1:0] step_q;
   logic [MW-1:0] x_next;
   logic [DW-1:0] cov_new;

   assign req_fire = req_valid && !req_stall;
   assign req_stall = (state_ff != skf_pkg::ST_IDLE);

   // shared multiplier: estimate step first, covariance next
   assign mul_a   = (state_ff == skf_pkg::ST_MULX) ? mag_ff : {1'b0, p1_ff};
   assign mul_b   = (state_ff == skf_pkg::ST_MULX) ? k_ff : skf_pkg::GAIN_ONE - k_ff;
   assign prod_in = PW'(mul_a) * PW'(mul_b);

   assign p_sum   = {1'b0, p_ff} + {1'b0, q_ff};
   assign diff    = {z_ff[DW-1], z_ff} - {x_ff[DW-1], x_ff};
   assign rem_sh  = {rem_ff, 1'b0};
   assign rem_sub = rem_sh - {1'b0, den_ff};
   assign step_q  = prod_ff[FB +: MW];
   assign x_next  = neg_ff ? ({x_ff[DW-1], x_ff} - step_q) : ({x_ff[DW-1], x_ff} + step_q);
   assign cov_new = prod_ff[FB +: DW];

   always_comb begin
      state_in     = state_ff;
      q_in         = q_ff;
      r_in         = r_ff;
      x0_in        = x0_ff;
      p0_in        = p0_ff;
      x_in         = x_ff;
      p_in         = p_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      z_in         = z_ff;
      p1_in        = p1_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      k_in         = k_ff;
      cnt_in       = cnt_ff;
      est_out_in   = est_out_ff;
      cov_out_in   = cov_out_ff;
      gain_out_in  = gain_out_ff;

      if (csr_write) begin
         case (skf_pkg::reg_index_type'(csr_index))
            skf_pkg::REG_PROCESS_NOISE:      q_in  = csr_wdata;
            skf_pkg::REG_MEASUREMENT_NOISE:  r_in  = csr_wdata;
            skf_pkg::REG_INITIAL_ESTIMATE:   x0_in = csr_wdata;
            skf_pkg::REG_INITIAL_COVARIANCE: p0_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         skf_pkg::ST_IDLE: begin
            if (req_fire) begin
               z_in = req_measurement;
               if (req_restart) begin
                  x_in = x0_ff;
                  p_in = p0_ff;
               end
               state_in = skf_pkg::ST_PRED;
            end
         end
         skf_pkg::ST_PRED: begin
            // saturating prediction and the innovation magnitude
            p1_in    = p_sum[DW] ? {DW{1'b1}} : p_sum[DW-1:0];
            neg_in   = diff[MW-1];
            mag_in   = diff[MW-1] ? (MW'(0) - diff) : diff;
            state_in = skf_pkg::ST_DEN;
         end
         skf_pkg::ST_DEN: begin
            den_in = {1'b0, p1_ff} + {1'b0, r_ff};
            rem_in = {1'b0, p1_ff};
            cnt_in = '0;
            if (r_ff == '0) begin
               k_in     = (p1_ff == '0) ? '0 : skf_pkg::GAIN_ONE;
               state_in = skf_pkg::ST_MULX;
            end else begin
               k_in     = '0;
               state_in = skf_pkg::ST_DIV;
            end
         end
         skf_pkg::ST_DIV: begin
            // restoring division, one gain bit per cycle
            if (!rem_sub[MW]) begin
               rem_in = rem_sub[MW-1:0];
               k_in   = {k_ff[GW-2:0], 1'b1};
            end else begin
               rem_in = rem_sh[MW-1:0];
               k_in   = {k_ff[GW-2:0], 1'b0};
            end
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(FB - 1))
               state_in = skf_pkg::ST_MULX;
         end
         skf_pkg::ST_MULX: begin
            state_in = skf_pkg::ST_MULP;
         end
         skf_pkg::ST_MULP: begin
            x_in     = x_next[DW-1:0];
            state_in = skf_pkg::ST_DONE;
         end
         skf_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               p_in         = cov_new;
               est_out_in   = x_ff;
               cov_out_in   = cov_new;
               gain_out_in  = k_ff;
               rsp_valid_in = 1'b1;
               state_in     = skf_pkg::ST_IDLE;
            end
         end
         default: state_in = skf_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= skf_pkg::ST_IDLE;
         q_ff         <= skf_pkg::RST_Q;
         r_ff         <= skf_pkg::RST_R;
         x0_ff        <= skf_pkg::RST_X;
         p0_ff        <= skf_pkg::RST_P;
         x_ff         <= skf_pkg::RST_X;
         p_ff         <= skf_pkg::RST_P;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         q_ff         <= q_in;
         r_ff         <= r_in;
         x0_ff        <= x0_in;
         p0_ff        <= p0_in;
         x_ff         <= x_in;
         p_ff         <= p_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      z_ff        <= z_in;
      p1_ff       <= p1_in;
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      den_ff      <= den_in;
      rem_ff      <= rem_in;
      k_ff        <= k_in;
      cnt_ff      <= cnt_in;
      prod_ff     <= prod_in;
      est_out_ff  <= est_out_in;
      cov_out_ff  <= cov_out_in;
      gain_out_ff <= gain_out_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_estimate   = est_out_ff;
   assign rsp_covariance = cov_out_ff;
   assign rsp_gain       = gain_out_ff;

   `SKF_ASSERT(a_accept_starts,
      req_fire |=> state_ff == skf_pkg::ST_PRED,
      "accepted beat did not start the update")
   `SKF_ASSERT(a_gain_range,
      (state_ff == skf_pkg::ST_MULX) |-> (k_ff <= skf_pkg::GAIN_ONE),
      "gain above one")
   `SKF_ASSERT(a_cov_bound,
      (state_ff == skf_pkg::ST_DONE) |-> (cov_new <= p1_ff),
      "covariance grew in the update")
   `SKF_ASSERT(a_done_delivers,
      (state_ff == skf_pkg::ST_DONE && !(rsp_valid_ff && rsp_stall))
         |=> (rsp_valid_ff && state_ff == skf_pkg::ST_IDLE),
      "result beat not delivered")

endmodule

/* verif/tb.sv */
// testbench for the scalar kalman filter: directed table, then random register settings
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic [skf_pkg::DATA_WIDTH-1:0] word_type;
   typedef logic [skf_pkg::GAIN_W-1:0]     gain_type;

   localparam longint unsigned WORD_MAX = (64'd1 << skf_pkg::DATA_WIDTH) - 64'd1;
   localparam longint unsigned UNITY    = 64'd1 << skf_pkg::FRAC_BITS;
   localparam word_type POS_MAX = {1'b0, {(skf_pkg::DATA_WIDTH-1){1'b1}}};
   localparam word_type NEG_MAX = {1'b1, {(skf_pkg::DATA_WIDTH-1){1'b0}}};

   localparam int RANDOM_PHASES   = 8;
   localparam int BEATS_PER_PHASE = 250;
   localparam int HOLDOFF_AT      = 700;
   localparam int HOLDOFF_CYCLES  = 400;
   localparam int PAUSE_AT        = 1200;
   localparam int TAIL_CYCLES     = 40;

   typedef struct {
      word_type estimate;
      word_type covariance;
      gain_type gain;
   } update_type;

   typedef enum {ROW_SETUP, ROW_BEAT, ROW_KNOWN} row_kind_type;

   typedef struct {
      row_kind_type kind;
      word_type     q, r, x0, p0;
      word_type     z;
      logic         restart;
      update_type   known;
   } directed_row_type;

   logic          clock;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   logic signed [skf_pkg::DATA_WIDTH-1:0] req_measurement = '0;
   logic          req_restart = 1'b0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   logic signed [skf_pkg::DATA_WIDTH-1:0] rsp_estimate;
   word_type      rsp_covariance;
   gain_type      rsp_gain;
   logic          csr_write = 1'b0;
   skf_pkg::reg_index_type csr_index = skf_pkg::REG_PROCESS_NOISE;
   word_type      csr_wdata = '0;

   // filter registers and state as the predictor sees them
   word_type q_noise = skf_pkg::RST_Q;
   word_type r_noise = skf_pkg::RST_R;
   word_type x_init  = skf_pkg::RST_X;
   word_type p_init  = skf_pkg::RST_P;
   word_type est_now = skf_pkg::RST_X;
   word_type cov_now = skf_pkg::RST_P;

   update_type pending_updates[$];

   int beats_sent    = 0;
   int updates_seen  = 0;
   int restarts_sent = 0;
   int setups_done   = 0;
   int fail_count    = 0;
   bit holdoff_done  = 1'b0;

   scalar_kalman_filter_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_measurement (req_measurement),
      .req_restart     (req_restart),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_estimate    (rsp_estimate),
      .rsp_covariance  (rsp_covariance),
      .rsp_gain        (rsp_gain),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin : watchdog
      #20_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // floor(a * k / 2^FRAC_BITS) for k up to unity, no overflow for a below 2^34
   function automatic longint unsigned frac_scale(longint unsigned a, longint unsigned k);
      return (a >> skf_pkg::FRAC_BITS) * k + (((a & (UNITY - 64'd1)) * k) >> skf_pkg::FRAC_BITS);
   endfunction

   function automatic update_type kalman_update(word_type z, logic rs);
      longint unsigned p1, den, rem, k, mag, step;
      longint          x, d;
      update_type      u;
      if (rs) begin
         est_now = x_init;
         cov_now = p_init;
      end
      p1 = 64'(cov_now) + 64'(q_noise);
      if (p1 > WORD_MAX) p1 = WORD_MAX;
      den = p1 + 64'(r_noise);
      rem = p1;
      k   = 0;
      // restoring division, one gain bit per pass
      if (den == 0) k = 0;
      else if (p1 >= den) k = UNITY;
      else begin
         for (int i = 0; i < skf_pkg::FRAC_BITS; i++) begin
            rem = rem << 1;
            k   = k << 1;
            if (rem >= den) begin
               rem = rem - den;
               k   = k | 64'd1;
            end
         end
      end
      x    = longint'($signed(est_now));
      d    = longint'($signed(z)) - x;
      mag  = (d < 0) ? $unsigned(-d) : $unsigned(d);
      step = frac_scale(mag, k);
      est_now = (d < 0) ? word_type'(x - longint'(step)) : word_type'(x + longint'(step));
      cov_now = word_type'(frac_scale(p1, UNITY - k));
      u.estimate   = est_now;
      u.covariance = cov_now;
      u.gain       = gain_type'(k);
      return u;
   endfunction

   function automatic word_type pick_setting(word_type dflt);
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2: return word_type'($urandom());
         3: return word_type'($urandom_range(0, 1 << 20));
         default: return dflt;
      endcase
   endfunction

   function automatic directed_row_type setup_row(word_type q, word_type r, word_type x0,
                                                  word_type p0);
      directed_row_type t;
      t.kind = ROW_SETUP;
      t.q    = q;
      t.r    = r;
      t.x0   = x0;
      t.p0   = p0;
      return t;
   endfunction

   function automatic directed_row_type beat_row(word_type z, logic rs);
      directed_row_type t;
      t.kind    = ROW_BEAT;
      t.z       = z;
      t.restart = rs;
      return t;
   endfunction

   function automatic directed_row_type known_row(word_type z, logic rs, word_type est,
                                                  word_type cov, gain_type k);
      directed_row_type t;
      t.kind             = ROW_KNOWN;
      t.z                = z;
      t.restart          = rs;
      t.known.estimate   = est;
      t.known.covariance = cov;
      t.known.gain       = k;
      return t;
   endfunction

   task automatic note_failure(string msg);
      fail_count++;
      if (fail_count <= 10) $display("%s", msg);
   endtask

   task automatic drain();
      if (req_valid) req_valid <= 1'b0;
      while (pending_updates.size() != 0) @(posedge clock);
   endtask

   task automatic put_reg(skf_pkg::reg_index_type idx, word_type v);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      case (idx)
         skf_pkg::REG_PROCESS_NOISE:      q_noise = v;
         skf_pkg::REG_MEASUREMENT_NOISE:  r_noise = v;
         skf_pkg::REG_INITIAL_ESTIMATE:   x_init  = v;
         skf_pkg::REG_INITIAL_COVARIANCE: p_init  = v;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic apply_settings(word_type q, word_type r, word_type x0, word_type p0);
      drain();
      put_reg(skf_pkg::REG_PROCESS_NOISE, q);
      put_reg(skf_pkg::REG_MEASUREMENT_NOISE, r);
      put_reg(skf_pkg::REG_INITIAL_ESTIMATE, x0);
      put_reg(skf_pkg::REG_INITIAL_COVARIANCE, p0);
      csr_write <= 1'b0;
      setups_done++;
   endtask

   task automatic offer_beat(word_type z, logic rs, logic typed, update_type known);
      int         gap;
      update_type u;
      gap = (beats_sent % 400 < 60) ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_measurement <= z;
      req_restart     <= rs;
      do @(posedge clock); while (req_stall);
      u = kalman_update(z, rs);
      pending_updates.push_back(typed ? known : u);
      beats_sent++;
      if (rs) restarts_sent++;
   endtask

   initial begin : result_side
      int         hold;
      update_type want;
      forever begin
         hold = (updates_seen % 500 < 80) ? 0 : $urandom_range(0, 3);
         // one long hold-off so the block backs up into its input
         if (updates_seen == HOLDOFF_AT && !holdoff_done) begin
            hold = HOLDOFF_CYCLES;
            holdoff_done = 1'b1;
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         updates_seen++;
         if (pending_updates.size() == 0) begin
            note_failure($sformatf("unexpected update: est %h cov %h gain %h",
                                   rsp_estimate, rsp_covariance, rsp_gain));
         end else begin
            want = pending_updates.pop_front();
            if (rsp_estimate !== want.estimate || rsp_covariance !== want.covariance ||
                rsp_gain !== want.gain)
               note_failure($sformatf(
                  "update %0d: expected est %h cov %h gain %h, got est %h cov %h gain %h",
                  updates_seen, want.estimate, want.covariance, want.gain,
                  rsp_estimate, rsp_covariance, rsp_gain));
         end
      end
   end

   initial begin : stimulus
      directed_row_type plan[$];
      directed_row_type row;
      update_type       none;
      longint           center;
      word_type         z;

      // defaults after reset
      plan.push_back(beat_row(skf_pkg::RST_X, 1'b0));
      plan.push_back(beat_row(POS_MAX, 1'b0));
      plan.push_back(beat_row(NEG_MAX, 1'b0));
      plan.push_back(beat_row('0, 1'b1));
      plan.push_back(beat_row('1, 1'b1));
      // zero denominator: estimate holds, covariance stays zero
      plan.push_back(setup_row('0, '0, 32'h1234_5678, '0));
      plan.push_back(known_row(POS_MAX, 1'b1, 32'h1234_5678, '0, '0));
      plan.push_back(known_row(NEG_MAX, 1'b0, 32'h1234_5678, '0, '0));
      // no measurement noise: unity gain, estimate jumps to the measurement
      plan.push_back(setup_row(32'd1, '0, 32'h1234_5678, '0));
      plan.push_back(known_row(POS_MAX, 1'b0, POS_MAX, '0, skf_pkg::GAIN_ONE));
      plan.push_back(known_row(NEG_MAX, 1'b0, NEG_MAX, '0, skf_pkg::GAIN_ONE));
      // covariance saturates, gain one half
      plan.push_back(setup_row('1, '1, POS_MAX, '1));
      plan.push_back(known_row(POS_MAX, 1'b1, POS_MAX, 32'h7FFF_FFFF, 17'h0_8000));
      plan.push_back(beat_row('0, 1'b0));
      plan.push_back(beat_row(NEG_MAX, 1'b1));
      // no prior uncertainty: gain zero
      plan.push_back(setup_row('0, 32'h0001_0000, NEG_MAX, '0));
      plan.push_back(known_row(POS_MAX, 1'b1, NEG_MAX, '0, '0));
      // back to defaults, restart with nothing else changed
      plan.push_back(setup_row(skf_pkg::RST_Q, skf_pkg::RST_R, skf_pkg::RST_X,
                               skf_pkg::RST_P));
      plan.push_back(beat_row(skf_pkg::RST_X, 1'b1));
      plan.push_back(beat_row(32'h002D_0000, 1'b0));
      plan.push_back(beat_row('0, 1'b1));
      plan.push_back(beat_row(32'h0001_8000, 1'b1));

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         row = plan[i];
         case (row.kind)
            ROW_SETUP: apply_settings(row.q, row.r, row.x0, row.p0);
            ROW_BEAT:  offer_beat(row.z, row.restart, 1'b0, row.known);
            default:   offer_beat(row.z, row.restart, 1'b1, row.known);
         endcase
      end

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         apply_settings(pick_setting(skf_pkg::RST_Q), pick_setting(skf_pkg::RST_R),
                        pick_setting(skf_pkg::RST_X), pick_setting(skf_pkg::RST_P));
         center = longint'($signed(word_type'($urandom()))) >>> $urandom_range(0, 20);
         for (int n = 0; n < BEATS_PER_PHASE; n++) begin
            // sender waits once for the pipeline to empty completely
            if (beats_sent == PAUSE_AT) drain();
            case ($urandom_range(0, 9))
               0:       z = $urandom_range(0, 1) ? POS_MAX : NEG_MAX;
               1, 2:    z = word_type'($urandom());
               default: z = word_type'(center + longint'($urandom_range(0, 1 << 18)) - (1 << 17));
            endcase
            offer_beat(z, ($urandom_range(0, 15) == 0), 1'b0, none);
         end
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("covered %0d beats (%0d restarts) over %0d register settings", beats_sent,
               restarts_sent, setups_done);
      $display("%0d updates compared, %0d failures", updates_seen, fail_count);
      if (fail_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
